// ----- design/cbtt_pkg.sv -----
// ----------------------------------------------------------------------------
// cbtt_pkg
// Types and codes shared by the one-shot callback timer table.
// ----------------------------------------------------------------------------
package cbtt_pkg;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_SET    = 2'd1,
    REQ_CANCEL = 2'd2,
    REQ_DONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SET,
    S_RESP
  } state_e;

  typedef struct packed {
    req_e        req_type;
    logic [31:0] now_ms;
    logic [31:0] delay_ms;
    logic [31:0] callback_addr;
    logic [31:0] user_word;
    logic        app_running;
  } req_t;

  typedef struct packed {
    logic        fired;
    logic [31:0] fired_callback;
    logic [31:0] fired_user;
    logic        table_full;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic set_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic pending;
    logic eval_hit;
    logic scan_done;
    logic slot_free;
    logic idx_last;
  } sts_t;

  localparam int unsigned SlotW = 96;

endpackage

// ----- design/one_shot_callback_timer_table_unit.sv -----
// ----------------------------------------------------------------------------
// one_shot_callback_timer_table_unit
// Table of one-shot timers with set, cancel, tick and callback-done requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; every request gives
// exactly one result, shown for one cycle with result_valid_o, which the
// receiver cannot hold off. Slots live in one RAM and are visited one per
// cycle, lowest index first, so the slot count sets the latency. A tick or
// cancel scan visits every slot (a tick stops once it fires the first
// expired slot), a set lands in the first free slot (table_full when the
// table is full), and a done request or an ignored tick skips the scan.
// The result is shown in the first cycle in which busy is low again, so the
// next request may be accepted in that same cycle.
// ----------------------------------------------------------------------------
module one_shot_callback_timer_table_unit #(
  parameter int unsigned TIMER_SLOTS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  cbtt_pkg::req_t req_i,
  output logic           result_valid_o,
  output cbtt_pkg::rsp_t result_o
);
  import cbtt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cbtt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .req_type_i    (req_i.req_type),
    .app_running_i (req_i.app_running),
    .sts_i         (sts),
    .cmd_o         (cmd),
    .busy          (busy)
  );

  cbtt_dp #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ----- design/cbtt_ram.sv -----
// ----------------------------------------------------------------------------
// cbtt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cbtt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/cbtt_ctrl.sv -----
// ----------------------------------------------------------------------------
// cbtt_ctrl
// Request sequencer: decodes the accepted item and steps the slot scan.
// ----------------------------------------------------------------------------
module cbtt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  cbtt_pkg::req_e req_type_i,
  input  logic          app_running_i,
  input  cbtt_pkg::sts_t sts_i,
  output cbtt_pkg::cmd_t cmd_o,
  output logic          busy
);
  import cbtt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (req_type_i)
            REQ_TICK:   state_d = (app_running_i && !sts_i.pending) ? S_SCAN : S_RESP;
            REQ_SET:    state_d = S_SET;
            REQ_CANCEL: state_d = S_SCAN;
            REQ_DONE:   state_d = S_RESP;
            default:    state_d = S_RESP;
          endcase
        end
      end
      S_SCAN: begin
        if (sts_i.eval_hit || sts_i.scan_done) begin
          state_d = S_IDLE;
        end
      end
      S_SET: begin
        if (sts_i.slot_free || sts_i.idx_last) begin
          state_d = S_IDLE;
        end
      end
      S_RESP:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      S_SCAN: begin
        cmd_o.scan   = 1'b1;
        cmd_o.finish = sts_i.eval_hit || sts_i.scan_done;
      end
      S_SET: begin
        cmd_o.set_step = 1'b1;
        cmd_o.finish   = sts_i.slot_free || sts_i.idx_last;
      end
      S_RESP:  cmd_o.finish = 1'b1;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ----- design/cbtt_dp.sv -----
// ----------------------------------------------------------------------------
// cbtt_dp
// Slot storage, active and pending marks, scan pipeline and result register.
// ----------------------------------------------------------------------------
module cbtt_dp #(
  parameter int unsigned TIMER_SLOTS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cbtt_pkg::req_t req_i,
  input  cbtt_pkg::cmd_t cmd_i,
  output cbtt_pkg::sts_t sts_o,
  output logic           result_valid_o,
  output cbtt_pkg::rsp_t result_o
);
  import cbtt_pkg::*;

  localparam int unsigned IdxW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TIMER_SLOTS - 1);

  logic [TIMER_SLOTS-1:0] active_q, active_d;
  logic                   pending_q, pending_d;
  logic [IdxW-1:0]        rd_idx_q, rd_idx_d;
  logic                   rd_done_q, rd_done_d;
  logic                   ev_valid_q, ev_valid_d;
  logic [IdxW-1:0]        ev_idx_q, ev_idx_d;
  logic                   rsp_valid_q;
  rsp_t                   rsp_q, rsp_d;

  req_e        req_q;
  logic [31:0] now_q;
  logic [31:0] exp_q;
  logic [31:0] cb_q;
  logic [31:0] usr_q;

  logic [SlotW-1:0] rd_data;
  logic [31:0]      rd_exp, rd_cb, rd_usr, diff;
  logic             ev_act, expired, cb_match, usr_match;
  logic             eval_hit, cancel_hit, scan_done, slot_free, idx_last, issue, we;

  cbtt_ram #(
    .WIDTH (SlotW),
    .DEPTH (TIMER_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (rd_idx_q),
    .wdata_i ({exp_q, cb_q, usr_q}),
    .raddr_i (rd_idx_q),
    .rdata_o (rd_data)
  );

  always_comb begin
    rd_exp     = rd_data[95:64];
    rd_cb      = rd_data[63:32];
    rd_usr     = rd_data[31:0];
    diff       = now_q - rd_exp;
    expired    = ~diff[31];
    cb_match   = (cb_q == 32'd0) || (rd_cb == cb_q);
    usr_match  = (usr_q == 32'd0) || (rd_usr == usr_q);
    ev_act     = active_q[ev_idx_q];
    eval_hit   = ev_valid_q && (req_q == REQ_TICK) && ev_act && expired;
    cancel_hit = ev_valid_q && (req_q == REQ_CANCEL) && ev_act && cb_match && usr_match;
    scan_done  = ev_valid_q && (ev_idx_q == LastIdx);
    slot_free  = ~active_q[rd_idx_q];
    idx_last   = (rd_idx_q == LastIdx);
    issue      = cmd_i.scan && !rd_done_q;
    we         = cmd_i.set_step && slot_free;
  end

  assign sts_o = '{
    pending:   pending_q,
    eval_hit:  eval_hit,
    scan_done: scan_done,
    slot_free: slot_free,
    idx_last:  idx_last
  };

  always_comb begin
    active_d   = active_q;
    pending_d  = pending_q;
    rd_idx_d   = rd_idx_q;
    rd_done_d  = rd_done_q;
    ev_valid_d = 1'b0;
    ev_idx_d   = ev_idx_q;
    rsp_d      = rsp_q;

    if (eval_hit || cancel_hit) begin
      active_d[ev_idx_q] = 1'b0;
    end
    if (we) begin
      active_d[rd_idx_q] = 1'b1;
    end
    if (eval_hit) begin
      pending_d = 1'b1;
    end

    if (cmd_i.load) begin
      rd_idx_d  = '0;
      rd_done_d = 1'b0;
      if (req_i.req_type == REQ_DONE) begin
        pending_d = 1'b0;
      end
    end else if (issue) begin
      ev_valid_d = !cmd_i.finish;
      ev_idx_d   = rd_idx_q;
      rd_done_d  = idx_last;
      if (!idx_last) begin
        rd_idx_d = rd_idx_q + 1'b1;
      end
    end else if (cmd_i.set_step && !slot_free && !idx_last) begin
      rd_idx_d = rd_idx_q + 1'b1;
    end

    if (cmd_i.finish) begin
      rsp_d.fired          = eval_hit;
      rsp_d.fired_callback = eval_hit ? rd_cb : 32'd0;
      rsp_d.fired_user     = eval_hit ? rd_usr : 32'd0;
      rsp_d.table_full     = cmd_i.set_step && !slot_free && idx_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= '0;
      pending_q   <= 1'b0;
      rd_idx_q    <= '0;
      rd_done_q   <= 1'b0;
      ev_valid_q  <= 1'b0;
      ev_idx_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      pending_q   <= pending_d;
      rd_idx_q    <= rd_idx_d;
      rd_done_q   <= rd_done_d;
      ev_valid_q  <= ev_valid_d;
      ev_idx_q    <= ev_idx_d;
      rsp_valid_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (cmd_i.load) begin
      req_q <= req_i.req_type;
      now_q <= req_i.now_ms;
      exp_q <= req_i.now_ms + req_i.delay_ms;
      cb_q  <= req_i.callback_addr;
      usr_q <= req_i.user_word;
    end
  end

  assign result_valid_o = rsp_valid_q;
  assign result_o       = rsp_q;

endmodule
